// File: hdl/aes128_pkg.sv
// Package: AES-128 types, S-box tables and round helpers.
`default_nettype none
package aes128_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } cipher_state_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_RUN
  } key_state_t;

  localparam logic [0:0] REQ_ENCRYPT = 1'b0;
  localparam logic [0:0] REQ_DECRYPT = 1'b1;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] RED_POLY = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? RED_POLY : 8'h00);
  endfunction

  // Byte n of the block is bits [127-8n -: 8]; state row n%4, column n/4.
  function automatic logic [127:0] sub_shift_fwd(input logic [127:0] s);
    logic [127:0] t;
    int src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = r + 4 * ((c + r) % 4);
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
      end
    end
    sub_shift_fwd = t;
  endfunction

  function automatic logic [127:0] sub_shift_inv(input logic [127:0] s);
    logic [127:0] t;
    int src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = r + 4 * ((c + r) % 4);
        t[127 - 8 * src -: 8] = INV_SBOX[s[127 - 8 * (r + 4 * c) -: 8]];
      end
    end
    sub_shift_inv = t;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_fwd = t;
  endfunction

  // Inverse mix as a 5,0,4,0 preconditioning then the forward mix.
  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] u, v;
    t = s;
    for (int c = 0; c < 4; c++) begin
      u = xtime(xtime(s[127 - 32 * c -: 8] ^ s[111 - 32 * c -: 8]));
      v = xtime(xtime(s[119 - 32 * c -: 8] ^ s[103 - 32 * c -: 8]));
      t[127 - 32 * c -: 8] = s[127 - 32 * c -: 8] ^ u;
      t[119 - 32 * c -: 8] = s[119 - 32 * c -: 8] ^ v;
      t[111 - 32 * c -: 8] = s[111 - 32 * c -: 8] ^ u;
      t[103 - 32 * c -: 8] = s[103 - 32 * c -: 8] ^ v;
    end
    mix_inv = mix_fwd(t);
  endfunction

endpackage
`default_nettype wire

// File: hdl/aes128_block_cipher.sv
// Top level: AES-128 ECB cipher with iterative round unit.
//
// Usage: write the key through cfg_we/cfg_index/cfg_data (index 0 key_high,
// index 1 key_low). Each write restarts the key schedule, which fills the
// round key store one key per cycle; in_stall is high during the write
// cycle and until the store is full.
// Input channel: in_valid/in_stall with req_type, block_high, block_low.
// Output channel: out_valid/out_stall with out_high, out_low.
// From input transfer to out_valid a block passes through the initial key
// addition and 10 rounds, one per cycle through the shared round unit.
// The round key read is registered in the cycle before the round that uses it.
// The block accepts one item at a time: the next item is taken the cycle
// after the result has been transferred.
// The result stays in the output register while out_stall is high.
// Reset clears the key to zero and runs the key schedule for that key, so
// the block is not ready after reset until the round key store is full.
`default_nettype none
module aes128_block_cipher
  import aes128_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [63:0] block_high,
  input  wire logic [63:0] block_low,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_high,
  output logic [63:0]      out_low
);

  cipher_state_t state, state_next;
  logic [63:0]   key_high, key_low;
  logic          ks_start, ks_busy;
  logic [3:0]    rd_idx, rd_idx_next;
  logic [127:0]  rkey;
  logic [127:0]  work;
  logic [3:0]    round;
  logic          dec;
  logic          first;
  logic          last_round;
  logic [127:0]  step;
  logic [127:0]  res;
  logic          in_xfer;

  assign in_xfer    = in_valid && !in_stall;
  assign ks_start   = cfg_we;
  assign last_round = (round == 4'd10) && !first;

  aes128_key_exp u_key (
    .clk    (clk),
    .rst    (rst),
    .start  (ks_start),
    .key    ({cfg_index == REG_KEY_HIGH ? cfg_data : key_high,
              cfg_index == REG_KEY_LOW  ? cfg_data : key_low}),
    .rd_idx (rd_idx_next),
    .rd_key (rkey),
    .busy   (ks_busy)
  );

  // Fetch the key for the round that rd_idx will point at next cycle.
  always_comb begin
    rd_idx_next = rd_idx;
    if (in_xfer) begin
      rd_idx_next = (req_type == REQ_DECRYPT) ? 4'd10 : 4'd0;
    end else if (state == ST_ROUND && !last_round) begin
      rd_idx_next = dec ? rd_idx - 4'd1 : rd_idx + 4'd1;
    end
  end

  // Shared round unit: the key arriving this cycle belongs to round "round".
  always_comb begin
    step = '0;
    res  = work;
    if (first) begin
      res = work ^ rkey;
    end else if (!dec) begin
      step = sub_shift_fwd(work);
      res  = (round == 4'd10) ? (step ^ rkey) : (mix_fwd(step) ^ rkey);
    end else begin
      step = sub_shift_inv(work) ^ rkey;
      res  = (round == 4'd10) ? step : mix_inv(step);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_ROUND;
      ST_ROUND: if (last_round) state_next = ST_DONE;
      ST_DONE:  if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE) || ks_busy;
    out_valid = (state == ST_DONE);
    out_high  = work[127:64];
    out_low   = work[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      key_high <= '0;
      key_low  <= '0;
      round    <= 4'd0;
      first    <= 1'b0;
      dec      <= 1'b0;
      rd_idx   <= 4'd0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      if (cfg_we && cfg_index == REG_KEY_HIGH) key_high <= cfg_data;
      if (cfg_we && cfg_index == REG_KEY_LOW)  key_low  <= cfg_data;
      if (in_xfer) begin
        dec    <= (req_type == REQ_DECRYPT);
        first  <= 1'b1;
        round  <= 4'd0;
      end else if (state == ST_ROUND && !last_round) begin
        first  <= 1'b0;
        round  <= first ? 4'd1 : round + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work <= '0;
    end else if (in_xfer) begin
      work <= {block_high, block_low};
    end else if (state == ST_ROUND) begin
      work <= res;
    end
  end

`ifndef SYNTHESIS
  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (round <= 4'd10)) else $error("round overrun");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(round == 4'd10)) else $error("early result");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(work))) else $error("result lost");
`endif

endmodule
`default_nettype wire

// File: hdl/aes128_key_exp.sv
// Key schedule: expands the cipher key one round key per cycle into a store.
`default_nettype none
module aes128_key_exp
  import aes128_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] key,
  input  wire logic [3:0]   rd_idx,
  output logic [127:0]      rd_key,
  output logic              busy
);

  key_state_t       state, state_next;
  logic [3:0]       cnt;
  logic [127:0]     cur;
  logic [7:0]       rcon;
  logic [127:0]     store [11];
  logic [127:0]     nxt;
  logic [31:0]      w0, w1, w2, w3, tw;

  always_comb begin
    w0 = cur[127:96];
    w1 = cur[95:64];
    w2 = cur[63:32];
    w3 = cur[31:0];
    tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    nxt[127:96] = w0 ^ tw;
    nxt[95:64]  = w1 ^ w0 ^ tw;
    nxt[63:32]  = w2 ^ w1 ^ w0 ^ tw;
    nxt[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ tw;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      KS_IDLE: if (start) state_next = KS_RUN;
      KS_RUN:  if (cnt == 4'd10 && !start) state_next = KS_IDLE;
      default: state_next = KS_IDLE;
    endcase
  end

  always_comb begin
    busy = (state == KS_RUN) || start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KS_RUN;
      cnt   <= 4'd0;
      cur   <= '0;
      rcon  <= 8'h01;
    end else begin
      state <= state_next;
      if (start) begin
        cnt  <= 4'd0;
        cur  <= key;
        rcon <= 8'h01;
      end else if (state == KS_RUN && cnt != 4'd10) begin
        cnt  <= cnt + 4'd1;
        cur  <= nxt;
        rcon <= xtime(rcon);
      end
    end
  end

  // Store the round key held in cur under its index.
  always_ff @(posedge clk) begin
    if (state == KS_RUN && !start) store[cnt] <= cur;
  end

  always_ff @(posedge clk) begin
    rd_key <= store[rd_idx];
  end

endmodule
`default_nettype wire
